@@ rtl/stsc_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, codes and reset values for the sun tracker servo scan control.
// Used by every module of the block; depends on nothing.
package stsc_pkg;

  // Field widths
  localparam int SAMPLE_BITS = 12;
  localparam int ANGLE_W     = 8;
  localparam int STEP_W      = 4;
  localparam int HOLD_W      = 16;
  localparam int FACTOR_W    = 7;
  localparam int PULSE_W     = 15;
  localparam int PHASE_W     = 2;
  localparam int CMD_W       = 8;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;

  // Register values after reset
  localparam logic [ANGLE_W-1:0]  ANGLE_LOW_RST    = 8'd35;
  localparam logic [ANGLE_W-1:0]  ANGLE_HIGH_RST   = 8'd115;
  localparam logic [STEP_W-1:0]   ANGLE_STEP_RST   = 4'd3;
  localparam logic [HOLD_W-1:0]   HOLD_TICKS_RST   = 16'd1000;
  localparam logic [FACTOR_W-1:0] PULSE_FACTOR_RST = 7'd20;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ANGLE_LOW    = 3'd0,
    REG_ANGLE_HIGH   = 3'd1,
    REG_ANGLE_STEP   = 3'd2,
    REG_HOLD_TICKS   = 3'd3,
    REG_PULSE_FACTOR = 3'd4
  } cfg_reg_t;

  // Command characters
  localparam logic [CMD_W-1:0] CMD_AUTO     = 8'h54; // 'T'
  localparam logic [CMD_W-1:0] CMD_AZ_UP    = 8'h61; // 'a'
  localparam logic [CMD_W-1:0] CMD_AZ_DOWN  = 8'h62; // 'b'
  localparam logic [CMD_W-1:0] CMD_ALT_UP   = 8'h63; // 'c'
  localparam logic [CMD_W-1:0] CMD_ALT_DOWN = 8'h64; // 'd'
  localparam logic [CMD_W-1:0] CMD_STOP     = 8'h73; // 's'

  // Item kinds
  localparam logic KIND_CMD  = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  // Latched manual move
  typedef enum logic [2:0] {
    MOVE_NONE     = 3'd0,
    MOVE_AZ_UP    = 3'd1,
    MOVE_AZ_DOWN  = 3'd2,
    MOVE_ALT_UP   = 3'd3,
    MOVE_ALT_DOWN = 3'd4,
    MOVE_STOP     = 3'd5
  } move_t;

  // Scan sequencer state
  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_AZ   = 4'b0010,
    PH_ALT  = 4'b0100,
    PH_HOLD = 4'b1000
  } phase_t;

  // Phase codes as reported on the result
  localparam logic [PHASE_W-1:0] PHASE_CODE_IDLE = 2'd0;
  localparam logic [PHASE_W-1:0] PHASE_CODE_AZ   = 2'd1;
  localparam logic [PHASE_W-1:0] PHASE_CODE_ALT  = 2'd2;
  localparam logic [PHASE_W-1:0] PHASE_CODE_HOLD = 2'd3;

  typedef struct packed {
    logic [ANGLE_W-1:0]  angle_low;
    logic [ANGLE_W-1:0]  angle_high;
    logic [STEP_W-1:0]   angle_step;
    logic [HOLD_W-1:0]   hold_ticks;
    logic [FACTOR_W-1:0] pulse_factor;
  } cfg_t;

  typedef struct packed {
    logic [ANGLE_W-1:0] azimuth;
    logic [ANGLE_W-1:0] altitude;
    logic               auto_on;
    logic [PHASE_W-1:0] phase;
  } status_t;

  function automatic logic [PHASE_W-1:0] phase_code(input phase_t ph);
    logic [PHASE_W-1:0] code;
    unique case (ph)
      PH_AZ:   code = PHASE_CODE_AZ;
      PH_ALT:  code = PHASE_CODE_ALT;
      PH_HOLD: code = PHASE_CODE_HOLD;
      default: code = PHASE_CODE_IDLE;
    endcase
    return code;
  endfunction

endpackage

@@ rtl/stsc_cfg.sv @@
`timescale 1ns / 1ps
// Configuration register file for the sun tracker servo scan control.
// Depends on stsc_pkg for widths, indexes and reset values.
module stsc_cfg (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [stsc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [stsc_pkg::CFG_DATA_W-1:0]     cfg_data,
  output stsc_pkg::cfg_t                      cfg
);

  // Always ready; each write is registered
  assign cfg_ready = 1'b1;

  // Write the addressed register, drop writes beyond the list
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.angle_low    <= stsc_pkg::ANGLE_LOW_RST;
      cfg.angle_high   <= stsc_pkg::ANGLE_HIGH_RST;
      cfg.angle_step   <= stsc_pkg::ANGLE_STEP_RST;
      cfg.hold_ticks   <= stsc_pkg::HOLD_TICKS_RST;
      cfg.pulse_factor <= stsc_pkg::PULSE_FACTOR_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (stsc_pkg::cfg_reg_t'(cfg_index))
        stsc_pkg::REG_ANGLE_LOW:    cfg.angle_low    <= cfg_data[stsc_pkg::ANGLE_W-1:0];
        stsc_pkg::REG_ANGLE_HIGH:   cfg.angle_high   <= cfg_data[stsc_pkg::ANGLE_W-1:0];
        stsc_pkg::REG_ANGLE_STEP:   cfg.angle_step   <= cfg_data[stsc_pkg::STEP_W-1:0];
        stsc_pkg::REG_HOLD_TICKS:   cfg.hold_ticks   <= cfg_data[stsc_pkg::HOLD_W-1:0];
        stsc_pkg::REG_PULSE_FACTOR: cfg.pulse_factor <= cfg_data[stsc_pkg::FACTOR_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

@@ rtl/stsc_core.sv @@
`timescale 1ns / 1ps
// Input register and controller state update (mode, manual moves, scan, hold).
// Depends on stsc_pkg for types and codes.
module stsc_core #(
  parameter int SAMPLE_BITS = stsc_pkg::SAMPLE_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          kind,
  input  logic [stsc_pkg::CMD_W-1:0]    command_byte,
  input  logic [SAMPLE_BITS-1:0]        light_sample,
  input  stsc_pkg::cfg_t                cfg,
  input  logic                          st_ready,
  output logic                          st_valid,
  output stsc_pkg::status_t             st
);

  // Input register
  logic                       in_full;
  logic                       kind_q;
  logic [stsc_pkg::CMD_W-1:0] cmd_q;
  logic [SAMPLE_BITS-1:0]     sample_q;

  // Controller state
  logic                           auto_mode, auto_mode_next;
  stsc_pkg::move_t                pending_move, pending_move_next;
  logic [stsc_pkg::ANGLE_W-1:0]   azimuth_angle, azimuth_angle_next;
  logic [stsc_pkg::ANGLE_W-1:0]   altitude_angle, altitude_angle_next;
  stsc_pkg::phase_t               phase, phase_next;
  logic [SAMPLE_BITS-1:0]         best_level, best_level_next;
  logic [stsc_pkg::ANGLE_W-1:0]   best_angle, best_angle_next;
  logic [stsc_pkg::HOLD_W-1:0]    hold_count, hold_count_next;

  // Scan and manual helpers
  logic [stsc_pkg::ANGLE_W-1:0]   axis, axis_new, best_pick;
  logic                           axis_in, take, keep_going;
  logic [stsc_pkg::ANGLE_W:0]     axis_sum, low_sum, high_ext;
  logic [stsc_pkg::ANGLE_W:0]     az_up, alt_up;
  logic [stsc_pkg::HOLD_W-1:0]    hold_inc;

  logic fire, in_ready, st_free;

  // Handshake: update state when the input item moves into the status register
  assign st_free  = !st_valid || st_ready;
  assign fire     = in_full && st_free;
  assign in_ready = !in_full || fire;
  assign in_stall = !in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full  <= 1'b0;
      st_valid <= 1'b0;
    end else begin
      if (in_ready) in_full <= in_valid;
      if (st_free) st_valid <= in_full;
    end
  end

  // Hold the item payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      kind_q   <= kind;
      cmd_q    <= command_byte;
      sample_q <= light_sample;
    end
  end

  // Shared scan datapath for the axis being swept
  assign axis       = (phase == stsc_pkg::PH_ALT) ? altitude_angle : azimuth_angle;
  assign axis_in    = axis <= cfg.angle_high;
  assign take       = axis_in && (sample_q > best_level);
  assign best_pick  = take ? axis : best_angle;
  assign axis_sum   = {1'b0, axis} + (stsc_pkg::ANGLE_W + 1)'(cfg.angle_step);
  assign high_ext   = {1'b0, cfg.angle_high};
  assign keep_going = axis_in && (axis_sum <= high_ext);
  assign axis_new   = keep_going ? axis_sum[stsc_pkg::ANGLE_W-1:0] : best_pick;

  // Manual move bounds
  assign az_up   = {1'b0, azimuth_angle} + (stsc_pkg::ANGLE_W + 1)'(cfg.angle_step);
  assign alt_up  = {1'b0, altitude_angle} + (stsc_pkg::ANGLE_W + 1)'(cfg.angle_step);
  assign low_sum = {1'b0, cfg.angle_low} + (stsc_pkg::ANGLE_W + 1)'(cfg.angle_step);

  assign hold_inc = hold_count + stsc_pkg::HOLD_W'(1);

  // Next-state logic for one item
  always_comb begin
    auto_mode_next      = auto_mode;
    pending_move_next   = pending_move;
    azimuth_angle_next  = azimuth_angle;
    altitude_angle_next = altitude_angle;
    phase_next          = phase;
    best_level_next     = best_level;
    best_angle_next     = best_angle;
    hold_count_next     = hold_count;

    if (kind_q == stsc_pkg::KIND_CMD) begin
      // Command byte: set mode, latch a move, leave hold on manual
      if (cmd_q == stsc_pkg::CMD_AUTO) begin
        auto_mode_next = 1'b1;
      end else begin
        auto_mode_next = 1'b0;
        unique case (cmd_q)
          stsc_pkg::CMD_AZ_UP:    pending_move_next = stsc_pkg::MOVE_AZ_UP;
          stsc_pkg::CMD_AZ_DOWN:  pending_move_next = stsc_pkg::MOVE_AZ_DOWN;
          stsc_pkg::CMD_ALT_UP:   pending_move_next = stsc_pkg::MOVE_ALT_UP;
          stsc_pkg::CMD_ALT_DOWN: pending_move_next = stsc_pkg::MOVE_ALT_DOWN;
          stsc_pkg::CMD_STOP:     pending_move_next = stsc_pkg::MOVE_STOP;
          default:                pending_move_next = pending_move;
        endcase
        if (phase == stsc_pkg::PH_HOLD) phase_next = stsc_pkg::PH_IDLE;
      end
    end else begin
      unique case (phase)
        stsc_pkg::PH_AZ, stsc_pkg::PH_ALT: begin
          // Sample, then step or park at the best angle
          if (phase == stsc_pkg::PH_AZ) azimuth_angle_next = axis_new;
          else altitude_angle_next = axis_new;
          if (keep_going) begin
            best_level_next = take ? sample_q : best_level;
            best_angle_next = best_pick;
          end else begin
            best_level_next = '0;
            best_angle_next = cfg.angle_low;
            if (phase == stsc_pkg::PH_AZ) begin
              phase_next          = stsc_pkg::PH_ALT;
              altitude_angle_next = cfg.angle_low;
            end else begin
              phase_next      = stsc_pkg::PH_HOLD;
              hold_count_next = '0;
            end
          end
        end
        stsc_pkg::PH_HOLD: begin
          // Count hold ticks; manual mode ends the hold
          if (!auto_mode) begin
            phase_next = stsc_pkg::PH_IDLE;
          end else begin
            hold_count_next = hold_inc;
            if (hold_inc >= cfg.hold_ticks) phase_next = stsc_pkg::PH_IDLE;
          end
        end
        default: begin
          if (auto_mode) begin
            // Start a scan at the low bound
            phase_next         = stsc_pkg::PH_AZ;
            azimuth_angle_next = cfg.angle_low;
            best_level_next    = '0;
            best_angle_next    = cfg.angle_low;
          end else begin
            // Manual step; clear the move at a limit
            unique case (pending_move)
              stsc_pkg::MOVE_AZ_UP: begin
                if (az_up < high_ext) azimuth_angle_next = az_up[stsc_pkg::ANGLE_W-1:0];
                else pending_move_next = stsc_pkg::MOVE_NONE;
              end
              stsc_pkg::MOVE_AZ_DOWN: begin
                if ({1'b0, azimuth_angle} > low_sum)
                  azimuth_angle_next = azimuth_angle - stsc_pkg::ANGLE_W'(cfg.angle_step);
                else pending_move_next = stsc_pkg::MOVE_NONE;
              end
              stsc_pkg::MOVE_ALT_UP: begin
                if (alt_up < high_ext) altitude_angle_next = alt_up[stsc_pkg::ANGLE_W-1:0];
                else pending_move_next = stsc_pkg::MOVE_NONE;
              end
              stsc_pkg::MOVE_ALT_DOWN: begin
                if ({1'b0, altitude_angle} > low_sum)
                  altitude_angle_next = altitude_angle - stsc_pkg::ANGLE_W'(cfg.angle_step);
                else pending_move_next = stsc_pkg::MOVE_NONE;
              end
              default: pending_move_next = stsc_pkg::MOVE_NONE;
            endcase
          end
        end
      endcase
    end
  end

  // Advance controller state on each item
  always_ff @(posedge clk) begin
    if (rst) begin
      auto_mode      <= 1'b0;
      pending_move   <= stsc_pkg::MOVE_NONE;
      azimuth_angle  <= stsc_pkg::ANGLE_LOW_RST;
      altitude_angle <= stsc_pkg::ANGLE_LOW_RST;
      phase          <= stsc_pkg::PH_IDLE;
      best_level     <= '0;
      best_angle     <= stsc_pkg::ANGLE_LOW_RST;
      hold_count     <= '0;
    end else if (fire) begin
      auto_mode      <= auto_mode_next;
      pending_move   <= pending_move_next;
      azimuth_angle  <= azimuth_angle_next;
      altitude_angle <= altitude_angle_next;
      phase          <= phase_next;
      best_level     <= best_level_next;
      best_angle     <= best_angle_next;
      hold_count     <= hold_count_next;
    end
  end

  // Capture the post-update status for this item
  always_ff @(posedge clk) begin
    if (fire) begin
      st.azimuth  <= azimuth_angle_next;
      st.altitude <= altitude_angle_next;
      st.auto_on  <= auto_mode_next;
      st.phase    <= stsc_pkg::phase_code(phase_next);
    end
  end

endmodule

@@ rtl/stsc_pulse.sv @@
`timescale 1ns / 1ps
// Pulse multiply and result register: angle times pulse factor per axis.
// Depends on stsc_pkg for widths and the status struct.
module stsc_pulse (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              st_valid,
  output logic                              st_ready,
  input  stsc_pkg::status_t                 st,
  input  logic [stsc_pkg::FACTOR_W-1:0]     pulse_factor,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [stsc_pkg::PULSE_W-1:0]      azimuth_pulse,
  output logic [stsc_pkg::PULSE_W-1:0]      altitude_pulse,
  output logic [stsc_pkg::ANGLE_W-1:0]      azimuth_now,
  output logic [stsc_pkg::ANGLE_W-1:0]      altitude_now,
  output logic                              auto_on,
  output logic [stsc_pkg::PHASE_W-1:0]      phase_now
);

  logic load;

  // Take a new item when the result register is empty or being drained
  assign st_ready = !out_valid || !out_stall;
  assign load     = st_valid && st_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (st_ready) begin
      out_valid <= st_valid;
    end
  end

  // Multiply and hold the result
  always_ff @(posedge clk) begin
    if (load) begin
      azimuth_pulse  <= stsc_pkg::PULSE_W'(st.azimuth) * stsc_pkg::PULSE_W'(pulse_factor);
      altitude_pulse <= stsc_pkg::PULSE_W'(st.altitude) * stsc_pkg::PULSE_W'(pulse_factor);
      azimuth_now    <= st.azimuth;
      altitude_now   <= st.altitude;
      auto_on        <= st.auto_on;
      phase_now      <= st.phase;
    end
  end

endmodule

@@ rtl/sun_tracker_servo_scan_control.sv @@
`timescale 1ns / 1ps
// Top level of the two-axis light tracker servo controller.
// Depends on stsc_pkg, stsc_cfg, stsc_core and stsc_pulse.

// Takes one item (command byte or light tick) per clock unless in_stall is high, and returns
// one result per item. An item passes an input register, then a state update of mode, manual
// move, scan sweep and hold counter into a status register, then a result register that
// multiplies each angle by the pulse factor. in_stall rises only when the input, status and
// result registers all hold items and out_stall is high. Configuration writes are taken
// every cycle and must be done while no item is in flight.
module sun_tracker_servo_scan_control #(
  parameter int SAMPLE_BITS = stsc_pkg::SAMPLE_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              kind,
  input  logic [stsc_pkg::CMD_W-1:0]        command_byte,
  input  logic [SAMPLE_BITS-1:0]            light_sample,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [stsc_pkg::PULSE_W-1:0]      azimuth_pulse,
  output logic [stsc_pkg::PULSE_W-1:0]      altitude_pulse,
  output logic [stsc_pkg::ANGLE_W-1:0]      azimuth_now,
  output logic [stsc_pkg::ANGLE_W-1:0]      altitude_now,
  output logic                              auto_on,
  output logic [stsc_pkg::PHASE_W-1:0]      phase_now,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [stsc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [stsc_pkg::CFG_DATA_W-1:0]   cfg_data
);

  stsc_pkg::cfg_t    cfg;
  stsc_pkg::status_t st;
  logic              st_valid, st_ready;

  stsc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  stsc_core #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .kind         (kind),
    .command_byte (command_byte),
    .light_sample (light_sample),
    .cfg          (cfg),
    .st_ready     (st_ready),
    .st_valid     (st_valid),
    .st           (st)
  );

  stsc_pulse u_pulse (
    .clk            (clk),
    .rst            (rst),
    .st_valid       (st_valid),
    .st_ready       (st_ready),
    .st             (st),
    .pulse_factor   (cfg.pulse_factor),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .azimuth_pulse  (azimuth_pulse),
    .altitude_pulse (altitude_pulse),
    .azimuth_now    (azimuth_now),
    .altitude_now   (altitude_now),
    .auto_on        (auto_on),
    .phase_now      (phase_now)
  );

  // A free output side lets the whole pipe advance
  a_no_stall_when_drained: assert property (@(posedge clk) disable iff (rst)
    !out_stall |-> !in_stall)
    else $error("input stalled while output drains");

  // A status item moved on shows up as a result next cycle
  a_status_to_result: assert property (@(posedge clk) disable iff (rst)
    (st_valid && st_ready) |=> out_valid)
    else $error("status item lost before result register");

  // Result angles come from the status item that was loaded
  a_result_angles: assert property (@(posedge clk) disable iff (rst)
    (st_valid && st_ready) |=>
      (azimuth_now == $past(st.azimuth)) && (altitude_now == $past(st.altitude)))
    else $error("result angles differ from loaded status");

endmodule

@@ tb/sv/tb_sun_tracker_servo_scan_control.sv @@
`timescale 1ns / 1ps
// Self-checking bench for sun_tracker_servo_scan_control: directed items, then random phases.
// Depends on stsc_pkg and the RTL top; a scoreboard class predicts each servo pose.

// One expected or observed result item
typedef struct packed {
  logic [stsc_pkg::PULSE_W-1:0] az_pulse;
  logic [stsc_pkg::PULSE_W-1:0] alt_pulse;
  logic [stsc_pkg::ANGLE_W-1:0] az_deg;
  logic [stsc_pkg::ANGLE_W-1:0] alt_deg;
  logic                         auto_on;
  logic [stsc_pkg::PHASE_W-1:0] phase;
} servo_pose_t;

// Tracks mode, manual move, sweep and hold, and queues the pose each item should produce
class servo_pose_board;
  int unsigned low_deg, high_deg, step_deg, hold_limit, factor;
  bit                           auto_mode;
  stsc_pkg::move_t              move;
  int unsigned                  az_deg, alt_deg, best_deg, best_lvl, hold_cnt;
  logic [stsc_pkg::PHASE_W-1:0] ph;
  servo_pose_t                  pending_poses[$];
  int                           errors;
  int                           poses_seen;

  function new();
    low_deg = stsc_pkg::ANGLE_LOW_RST; high_deg = stsc_pkg::ANGLE_HIGH_RST;
    step_deg = stsc_pkg::ANGLE_STEP_RST;
    hold_limit = stsc_pkg::HOLD_TICKS_RST; factor = stsc_pkg::PULSE_FACTOR_RST;
    auto_mode = 1'b0; move = stsc_pkg::MOVE_NONE;
    az_deg = stsc_pkg::ANGLE_LOW_RST; alt_deg = stsc_pkg::ANGLE_LOW_RST;
    best_deg = stsc_pkg::ANGLE_LOW_RST;
    best_lvl = 0; hold_cnt = 0; ph = stsc_pkg::PHASE_CODE_IDLE;
    errors = 0; poses_seen = 0;
  endfunction

  function void set_reg(stsc_pkg::cfg_reg_t idx, logic [stsc_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      stsc_pkg::REG_ANGLE_LOW:    low_deg = data[stsc_pkg::ANGLE_W-1:0];
      stsc_pkg::REG_ANGLE_HIGH:   high_deg = data[stsc_pkg::ANGLE_W-1:0];
      stsc_pkg::REG_ANGLE_STEP:   step_deg = data[stsc_pkg::STEP_W-1:0];
      stsc_pkg::REG_HOLD_TICKS:   hold_limit = data[stsc_pkg::HOLD_W-1:0];
      stsc_pkg::REG_PULSE_FACTOR: factor = data[stsc_pkg::FACTOR_W-1:0];
      default: ;
    endcase
  endfunction

  function int pending();
    return pending_poses.size();
  endfunction

  // Sample one sweep position, then advance or park; returns the new axis angle
  function int unsigned sweep_axis(int unsigned axis, int unsigned level, bit last_axis);
    int unsigned parked;
    if (axis <= high_deg && level > best_lvl) begin
      best_lvl = level;
      best_deg = axis;
    end
    if (axis <= high_deg && axis + step_deg <= high_deg) return axis + step_deg;
    parked = best_deg;
    best_lvl = 0;
    best_deg = low_deg;
    if (last_axis) begin
      ph = stsc_pkg::PHASE_CODE_HOLD;
      hold_cnt = 0;
    end else begin
      ph = stsc_pkg::PHASE_CODE_ALT;
      alt_deg = low_deg;
    end
    return parked;
  endfunction

  // Perform the latched move while strictly inside the limits, else drop it
  function void manual_step();
    case (move)
      stsc_pkg::MOVE_AZ_UP:
        if (az_deg + step_deg < high_deg) az_deg += step_deg;
        else move = stsc_pkg::MOVE_NONE;
      stsc_pkg::MOVE_AZ_DOWN:
        if (az_deg > low_deg + step_deg) az_deg -= step_deg;
        else move = stsc_pkg::MOVE_NONE;
      stsc_pkg::MOVE_ALT_UP:
        if (alt_deg + step_deg < high_deg) alt_deg += step_deg;
        else move = stsc_pkg::MOVE_NONE;
      stsc_pkg::MOVE_ALT_DOWN:
        if (alt_deg > low_deg + step_deg) alt_deg -= step_deg;
        else move = stsc_pkg::MOVE_NONE;
      default: move = stsc_pkg::MOVE_NONE;
    endcase
  endfunction

  // Advance the tracker by one accepted item and queue the resulting pose
  function void note_input(logic k, logic [stsc_pkg::CMD_W-1:0] cmd,
                           logic [stsc_pkg::SAMPLE_BITS-1:0] level);
    servo_pose_t pose;
    if (k == stsc_pkg::KIND_CMD) begin
      if (cmd == stsc_pkg::CMD_AUTO) begin
        auto_mode = 1'b1;
      end else begin
        auto_mode = 1'b0;
        case (cmd)
          stsc_pkg::CMD_AZ_UP:    move = stsc_pkg::MOVE_AZ_UP;
          stsc_pkg::CMD_AZ_DOWN:  move = stsc_pkg::MOVE_AZ_DOWN;
          stsc_pkg::CMD_ALT_UP:   move = stsc_pkg::MOVE_ALT_UP;
          stsc_pkg::CMD_ALT_DOWN: move = stsc_pkg::MOVE_ALT_DOWN;
          stsc_pkg::CMD_STOP:     move = stsc_pkg::MOVE_STOP;
          default: ;
        endcase
        if (ph == stsc_pkg::PHASE_CODE_HOLD) ph = stsc_pkg::PHASE_CODE_IDLE;
      end
    end else if (ph == stsc_pkg::PHASE_CODE_AZ) begin
      az_deg = sweep_axis(az_deg, level, 1'b0);
    end else if (ph == stsc_pkg::PHASE_CODE_ALT) begin
      alt_deg = sweep_axis(alt_deg, level, 1'b1);
    end else if (ph == stsc_pkg::PHASE_CODE_HOLD) begin
      if (!auto_mode) begin
        ph = stsc_pkg::PHASE_CODE_IDLE;
      end else begin
        hold_cnt = (hold_cnt + 1) & 32'hFFFF;
        if (hold_cnt >= hold_limit) ph = stsc_pkg::PHASE_CODE_IDLE;
      end
    end else if (auto_mode) begin
      ph = stsc_pkg::PHASE_CODE_AZ;
      az_deg = low_deg;
      best_lvl = 0;
      best_deg = low_deg;
    end else begin
      manual_step();
    end
    pose.az_pulse  = stsc_pkg::PULSE_W'(az_deg * factor);
    pose.alt_pulse = stsc_pkg::PULSE_W'(alt_deg * factor);
    pose.az_deg    = az_deg[stsc_pkg::ANGLE_W-1:0];
    pose.alt_deg   = alt_deg[stsc_pkg::ANGLE_W-1:0];
    pose.auto_on   = auto_mode;
    pose.phase     = ph;
    pending_poses.push_back(pose);
  endfunction

  task report(string field, logic [31:0] got, logic [31:0] want);
    $display("mismatch on %s of result %0d: got %0d, want %0d", field, poses_seen, got, want);
    errors++;
  endtask

  // Compare one observed pose with the oldest expected one
  task check_result(servo_pose_t got);
    servo_pose_t want;
    poses_seen++;
    if (pending_poses.size() == 0) begin
      report("unexpected result", got.az_deg, 0);
      return;
    end
    want = pending_poses.pop_front();
    if (got.az_pulse !== want.az_pulse) report("azimuth_pulse", got.az_pulse, want.az_pulse);
    if (got.alt_pulse !== want.alt_pulse)
      report("altitude_pulse", got.alt_pulse, want.alt_pulse);
    if (got.az_deg !== want.az_deg) report("azimuth_now", got.az_deg, want.az_deg);
    if (got.alt_deg !== want.alt_deg) report("altitude_now", got.alt_deg, want.alt_deg);
    if (got.auto_on !== want.auto_on) report("auto_on", got.auto_on, want.auto_on);
    if (got.phase !== want.phase) report("phase_now", got.phase, want.phase);
  endtask
endclass

module tb_sun_tracker_servo_scan_control;

  localparam int PHASES       = 9;
  localparam int PHASE_ITEMS  = 215;
  localparam int DRAIN_CYCLES = 8;
  localparam int LONG_STALL   = 48;
  localparam int QUIET_LIMIT  = 2000;

  logic                             clk;
  logic                             rst;
  logic                             in_valid;
  logic                             in_stall;
  logic                             kind;
  logic [stsc_pkg::CMD_W-1:0]       command_byte;
  logic [stsc_pkg::SAMPLE_BITS-1:0] light_sample;
  logic                             out_valid;
  logic                             out_stall;
  logic [stsc_pkg::PULSE_W-1:0]     azimuth_pulse;
  logic [stsc_pkg::PULSE_W-1:0]     altitude_pulse;
  logic [stsc_pkg::ANGLE_W-1:0]     azimuth_now;
  logic [stsc_pkg::ANGLE_W-1:0]     altitude_now;
  logic                             auto_on;
  logic [stsc_pkg::PHASE_W-1:0]     phase_now;
  logic                             cfg_valid;
  logic                             cfg_ready;
  logic [stsc_pkg::CFG_IDX_W-1:0]   cfg_index;
  logic [stsc_pkg::CFG_DATA_W-1:0]  cfg_data;

  servo_pose_board                  board;
  int                               gap_odds;
  int                               stall_odds;
  bit                               stretch_req;
  int                               quiet_cycles;
  logic [stsc_pkg::SAMPLE_BITS-1:0] prev_level;

  sun_tracker_servo_scan_control uut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .kind           (kind),
    .command_byte   (command_byte),
    .light_sample   (light_sample),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .azimuth_pulse  (azimuth_pulse),
    .altitude_pulse (altitude_pulse),
    .azimuth_now    (azimuth_now),
    .altitude_now   (altitude_now),
    .auto_on        (auto_on),
    .phase_now      (phase_now),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Sample every handshake at the rising edge and feed the scoreboard
  initial begin : monitor
    servo_pose_t got;
    bit          moved;
    quiet_cycles = 0;
    forever begin
      @(posedge clk);
      if (!rst) begin
        moved = 1'b0;
        if (cfg_valid && cfg_ready) begin
          board.set_reg(stsc_pkg::cfg_reg_t'(cfg_index), cfg_data);
          moved = 1'b1;
        end
        if (in_valid && !in_stall) begin
          board.note_input(kind, command_byte, light_sample);
          moved = 1'b1;
        end
        if (out_valid && !out_stall) begin
          got.az_pulse  = azimuth_pulse;
          got.alt_pulse = altitude_pulse;
          got.az_deg    = azimuth_now;
          got.alt_deg   = altitude_now;
          got.auto_on   = auto_on;
          got.phase     = phase_now;
          board.check_result(got);
          moved = 1'b1;
        end
        quiet_cycles = moved ? 0 : quiet_cycles + 1;
      end
    end
  end

  // End the run if nothing moves for too long
  initial begin : watchdog
    @(negedge rst);
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("tb_sun_tracker_servo_scan_control NOT OK");
    $finish;
  end

  // Result side: random stall bursts, plus one long hold-off on request
  initial begin : result_sink
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (stretch_req) begin
        stretch_req = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_STALL) @(negedge clk);
        out_stall <= 1'b0;
      end else if (stall_odds != 0 && $urandom_range(0, stall_odds - 1) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 13)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Offer one item, maybe after a random gap, and hold it until accepted
  task automatic offer(logic k, logic [stsc_pkg::CMD_W-1:0] cmd,
                       logic [stsc_pkg::SAMPLE_BITS-1:0] level);
    if (gap_odds != 0 && $urandom_range(0, gap_odds - 1) == 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13) - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid     <= 1'b1;
    kind         <= k;
    command_byte <= cmd;
    light_sample <= level;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic tick(logic [stsc_pkg::SAMPLE_BITS-1:0] level);
    offer(stsc_pkg::KIND_TICK, '0, level);
  endtask

  task automatic command(logic [stsc_pkg::CMD_W-1:0] cmd);
    offer(stsc_pkg::KIND_CMD, cmd, '0);
  endtask

  task automatic write_reg(stsc_pkg::cfg_reg_t idx, logic [stsc_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic program_regs(int lo, int hi, int st, int hold, int fac);
    write_reg(stsc_pkg::REG_ANGLE_LOW, stsc_pkg::CFG_DATA_W'(lo));
    write_reg(stsc_pkg::REG_ANGLE_HIGH, stsc_pkg::CFG_DATA_W'(hi));
    write_reg(stsc_pkg::REG_ANGLE_STEP, stsc_pkg::CFG_DATA_W'(st));
    write_reg(stsc_pkg::REG_HOLD_TICKS, stsc_pkg::CFG_DATA_W'(hold));
    write_reg(stsc_pkg::REG_PULSE_FACTOR, stsc_pkg::CFG_DATA_W'(fac));
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Drop valid, wait for every pose to come back, then let the pipe drain
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Dark, saturated, repeated (tie) or random light level
  function automatic logic [stsc_pkg::SAMPLE_BITS-1:0] light_level();
    case ($urandom_range(0, 9))
      0: light_level = '0;
      1: light_level = '1;
      2: light_level = prev_level;
      default: light_level = stsc_pkg::SAMPLE_BITS'(
                 $urandom_range(0, (1 << stsc_pkg::SAMPLE_BITS) - 1));
    endcase
    prev_level = light_level;
  endfunction

  function automatic logic [stsc_pkg::CMD_W-1:0] manual_cmd();
    case ($urandom_range(0, 4))
      0: manual_cmd = stsc_pkg::CMD_AZ_UP;
      1: manual_cmd = stsc_pkg::CMD_AZ_DOWN;
      2: manual_cmd = stsc_pkg::CMD_ALT_UP;
      3: manual_cmd = stsc_pkg::CMD_ALT_DOWN;
      default: manual_cmd = stsc_pkg::CMD_STOP;
    endcase
  endfunction

  // Mostly ticks so scans run to the end; manual style leans on move commands
  task automatic random_item(bit manual_style);
    int r;
    r = $urandom_range(0, 99);
    if (r < (manual_style ? 55 : 80))
      offer(stsc_pkg::KIND_TICK, stsc_pkg::CMD_W'($urandom_range(0, 255)), light_level());
    else if (r < (manual_style ? 60 : 91))
      offer(stsc_pkg::KIND_CMD, stsc_pkg::CMD_AUTO, light_level());
    else if (r < 97)
      offer(stsc_pkg::KIND_CMD, manual_cmd(), light_level());
    else
      offer(stsc_pkg::KIND_CMD, stsc_pkg::CMD_W'($urandom_range(0, 255)), light_level());
  endtask

  initial begin : stimulus
    int lo, hi, swap, hold;
    board        = new();
    rst          = 1'b1;
    in_valid     = 1'b0;
    kind         = stsc_pkg::KIND_CMD;
    command_byte = '0;
    light_sample = '0;
    cfg_valid    = 1'b0;
    cfg_index    = stsc_pkg::REG_ANGLE_LOW;
    cfg_data     = '0;
    gap_odds     = 0;
    stall_odds   = 0;
    stretch_req  = 1'b0;
    prev_level   = '0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // Narrow window: manual moves, limit clears, then a full scan
    program_regs(10, 20, 5, 1, 111);
    command(stsc_pkg::CMD_AZ_DOWN);
    tick('1);
    command(8'hFF);              // other byte keeps the latched move
    tick('0);
    command(stsc_pkg::CMD_ALT_DOWN);
    tick(12'd100);
    command(stsc_pkg::CMD_AZ_UP);
    tick(12'd100);               // upper limit clears the move
    command(stsc_pkg::CMD_STOP);
    tick(12'd1);
    command(stsc_pkg::CMD_AUTO);
    tick(12'd50);                // start scan, sample ignored
    command(stsc_pkg::CMD_ALT_UP); // scan keeps running in manual mode
    tick(12'd7);
    tick(12'd7);                 // tie does not replace the best
    tick('1);                    // park azimuth at the brightest angle
    tick('0);
    tick('0);
    tick('0);                    // dark sweep parks at the low angle
    tick(12'd9);                 // manual mode ends the hold
    command(8'h00);

    // Low above high: empty sweeps, then a byte during hold
    settle();
    program_regs(180, 0, 15, 0, 1);
    command(stsc_pkg::CMD_AUTO);
    tick(12'd300);
    tick(12'd400);
    tick(12'd500);
    command(8'h7F);
    settle();

    // Random phases over several register settings
    for (int p = 0; p < PHASES; p++) begin
      gap_odds   = (p == PHASES - 1) ? 0 : (p % 4 == 0) ? 5 : (p % 4 == 1) ? 0 :
                   (p % 4 == 2) ? 12 : 3;
      stall_odds = (p == PHASES - 1) ? 0 : (p % 4 == 0) ? 0 : (p % 4 == 1) ? 6 :
                   (p % 4 == 2) ? 4 : 12;
      case (p)
        0: program_regs(stsc_pkg::ANGLE_LOW_RST, stsc_pkg::ANGLE_HIGH_RST,
                        stsc_pkg::ANGLE_STEP_RST, stsc_pkg::HOLD_TICKS_RST,
                        stsc_pkg::PULSE_FACTOR_RST);
        1: program_regs(0, 180, 15, 65535, 111);
        2: program_regs(0, 40, 1, 0, 1);
        default: begin
          lo = $urandom_range(0, 180);
          hi = $urandom_range(0, 180);
          if (lo > hi && $urandom_range(0, 4) != 0) begin
            swap = lo;
            lo   = hi;
            hi   = swap;
          end
          hold = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 30);
          program_regs(lo, hi, $urandom_range(1, 15), hold, $urandom_range(1, 111));
        end
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // Long receiver hold-off while items keep coming
        if (p == 1 && i == 60) stretch_req = 1'b1;
        random_item(p % 4 == 3);
      end
      settle();
    end

    if (board.errors == 0) $display("tb_sun_tracker_servo_scan_control OK");
    else $display("tb_sun_tracker_servo_scan_control NOT OK");
    $finish;
  end

endmodule
